[hw/rtl/dchl_pkg.sv]
// ----------------------------------------------------------------------------
// dchl_pkg: shared constants and crc step functions
// crc polynomials and init values, default sizes and the action codes of the lookup sequencer
// ----------------------------------------------------------------------------
package dchl_pkg;

    localparam int DEF_TABLE_DEPTH = 1024;
    localparam int DEF_MAX_NAME    = 256;

    localparam logic [31:0] POLY_LONG  = 32'h04C1_1DB7;
    localparam logic [15:0] POLY_SHORT = 16'h1021;
    localparam logic [31:0] INIT_LONG  = 32'hFFFF_FFFF;
    localparam logic [15:0] INIT_SHORT = 16'hFFFF;

    // operation codes for the action field
    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_CHAR = 1'b1;

    // one byte through the 32-bit crc, msb first
    function automatic logic [31:0] crc32_byte(input logic [31:0] c, input logic [7:0] ch);
        logic [31:0] s;
        s = c ^ {ch, 24'h0};
        for (int k = 0; k < 8; k++) begin
            s = s[31] ? ((s << 1) ^ POLY_LONG) : (s << 1);
        end
        return s;
    endfunction

    // one byte through the 16-bit crc, msb first
    function automatic logic [15:0] crc16_byte(input logic [15:0] c, input logic [7:0] ch);
        logic [15:0] s;
        s = c ^ {ch, 8'h0};
        for (int k = 0; k < 8; k++) begin
            s = s[15] ? ((s << 1) ^ POLY_SHORT) : (s << 1);
        end
        return s;
    endfunction

endpackage

[hw/rtl/dchl_name_cell.sv]
// ----------------------------------------------------------------------------
// dchl_name_cell: one character slot of the name shift chain
// in push mode takes the neighbour's byte, in pop mode hands its byte down
// ----------------------------------------------------------------------------
module dchl_name_cell
    import dchl_pkg::*;
(
    input  logic       clk,
    input  logic       push,
    input  logic       pop,
    input  logic [7:0] push_in,
    input  logic [7:0] pop_in,
    output logic [7:0] data
);

    logic [7:0] data_reg;
    logic [7:0] data_next;

    always_comb
    begin
        data_next = data_reg;
        if (push)
        begin
            data_next = push_in;
        end
        else if (pop)
        begin
            data_next = pop_in;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

[hw/rtl/dchl_name_chain.sv]
// ----------------------------------------------------------------------------
// dchl_name_chain: row of name cells acting as a stack
// newest character sits in cell 0; pop shifts toward cell 0
// ----------------------------------------------------------------------------
module dchl_name_chain
    import dchl_pkg::*;
#(
    parameter int MAX_NAME = DEF_MAX_NAME
)
(
    input  logic       clk,
    input  logic       push,
    input  logic       pop,
    input  logic [7:0] char_in,
    output logic [7:0] top
);

    logic [7:0] cell_data [MAX_NAME];

    for (genvar g = 0; g < MAX_NAME; g++)
    begin : g_cell
        logic [7:0] push_src;
        logic [7:0] pop_src;
        if (g == 0)
        begin : g_first
            assign push_src = char_in;
        end
        else
        begin : g_rest
            assign push_src = cell_data[g-1];
        end
        if (g == MAX_NAME - 1)
        begin : g_end
            assign pop_src = 8'h00;
        end
        else
        begin : g_mid
            assign pop_src = cell_data[g+1];
        end
        dchl_name_cell u_cell (
            .clk     (clk),
            .push    (push),
            .pop     (pop),
            .push_in (push_src),
            .pop_in  (pop_src),
            .data    (cell_data[g])
        );
    end

    assign top = cell_data[0];

endmodule

[hw/rtl/dual_crc_name_hash_lookup.sv]
// ----------------------------------------------------------------------------
// dual_crc_name_hash_lookup: name hashing and hash table lookup
// forward crc32 per character, reversed crc16 and linear table search at end
// ----------------------------------------------------------------------------
//  channel  | signals                                   | handshake
//  input    | action entry_index entry_hash32 ...       | start & !busy
//  result   | hash_long hash_short found match_index    | done strobe
//  config   | cfg_data                                  | cfg_valid & cfg_ready
//
// load items and plain characters are taken while idle and leave busy low.
// after a last character busy stays high while the crc16 runs over the stored
// name (one cell popped per cycle) and then during the search (one table read
// per cycle, count capped at the table depth; shorter on a hit, no reads for a
// zero count); done follows in the first idle cycle, in which the next item can
// already be taken.
// reset clears control, the entry count and the crc32 only; table and name chain are undefined until written.
// results cannot be stalled; done is high for one cycle.
module dual_crc_name_hash_lookup
    import dchl_pkg::*;
#(
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
    parameter int MAX_NAME    = DEF_MAX_NAME
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        action,
    input  logic [9:0]  entry_index,
    input  logic [31:0] entry_hash32,
    input  logic [15:0] entry_hash16,
    input  logic [7:0]  name_char,
    input  logic        last,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [10:0] cfg_data,
    output logic        done,
    output logic [31:0] hash_long,
    output logic [15:0] hash_short,
    output logic        found,
    output logic [9:0]  match_index
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int LW = $clog2(MAX_NAME + 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_REV  = 2'd1;
    localparam logic [1:0] ST_SRCH = 2'd2;

    logic [1:0]    state_reg, state_next;
    logic [10:0]   count_reg;
    logic [31:0]   crc_reg, crc_next;
    logic [15:0]   crcs_reg, crcs_next;
    logic [LW-1:0] len_reg, len_next;
    logic [CW-1:0] limit_reg, limit_next;
    logic [CW-1:0] rd_ptr_reg, rd_ptr_next;
    logic          rd_vld_reg, rd_vld_next;
    logic [AW-1:0] rd_idx_reg;
    logic          done_reg, done_next;
    logic          found_reg, found_next;
    logic [9:0]    midx_reg, midx_next;
    logic [31:0]   tab_long [TABLE_DEPTH];
    logic [15:0]   tab_short [TABLE_DEPTH];
    logic [31:0]   rd_long_reg;
    logic [15:0]   rd_short_reg;
    logic          accept, ld_en, ch_en, push, pop;
    logic [7:0]    top;
    logic [31:0]   crc_upd;
    logic [31:0]   hl_reg;

    assign accept = start && !busy;
    assign ld_en  = accept && action == ACT_LOAD && {22'h0, entry_index} < 32'(TABLE_DEPTH);
    assign ch_en  = accept && action == ACT_CHAR;
    assign push   = ch_en && len_reg < LW'(MAX_NAME);
    assign pop    = state_reg == ST_REV && len_reg != '0;
    assign busy   = state_reg != ST_IDLE;
    assign cfg_ready = !busy;
    assign crc_upd = crc32_byte(crc_reg, name_char);

    dchl_name_chain #(.MAX_NAME(MAX_NAME)) u_chain (
        .clk     (clk),
        .push    (push),
        .pop     (pop),
        .char_in (name_char),
        .top     (top)
    );

    always_ff @(posedge clk)
    begin
        if (ld_en)
        begin
            tab_long[entry_index[AW-1:0]]  <= entry_hash32;
            tab_short[entry_index[AW-1:0]] <= entry_hash16;
        end
        rd_long_reg  <= tab_long[rd_ptr_reg[AW-1:0]];
        rd_short_reg <= tab_short[rd_ptr_reg[AW-1:0]];
        rd_idx_reg   <= rd_ptr_reg[AW-1:0];
    end

    always_comb
    begin
        state_next  = state_reg;
        crc_next    = crc_reg;
        crcs_next   = crcs_reg;
        len_next    = len_reg;
        limit_next  = limit_reg;
        rd_ptr_next = rd_ptr_reg;
        rd_vld_next = 1'b0;
        done_next   = 1'b0;
        found_next  = found_reg;
        midx_next   = midx_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (ch_en)
                begin
                    crc_next = crc_upd;
                    if (push)
                    begin
                        len_next = len_reg + 1'b1;
                    end
                    if (last)
                    begin
                        state_next = ST_REV;
                        crcs_next  = INIT_SHORT;
                        limit_next = (count_reg > 11'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH)
                                                                  : CW'(count_reg);
                    end
                end
            end
            ST_REV:
            begin
                if (pop)
                begin
                    crcs_next = crc16_byte(crcs_reg, top);
                    len_next  = len_reg - 1'b1;
                end
                else
                begin
                    state_next  = ST_SRCH;
                    rd_ptr_next = '0;
                    found_next  = 1'b0;
                    midx_next   = '0;
                end
            end
            ST_SRCH:
            begin
                // one slot read per cycle, compared in the cycle after the read
                if (rd_ptr_reg < limit_reg && !found_reg)
                begin
                    rd_vld_next = 1'b1;
                    rd_ptr_next = rd_ptr_reg + 1'b1;
                end
                if (rd_vld_reg && !found_reg && rd_long_reg == ~crc_reg
                    && rd_short_reg == ~crcs_reg)
                begin
                    found_next  = 1'b1;
                    midx_next   = 10'(rd_idx_reg);
                    rd_vld_next = 1'b0;
                end
                if (found_next || (!rd_vld_reg && !rd_vld_next))
                begin
                    state_next = ST_IDLE;
                    done_next  = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        if (done_next)
        begin
            crc_next = INIT_LONG;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            count_reg  <= '0;
            crc_reg    <= INIT_LONG;
            len_reg    <= '0;
            rd_vld_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            crc_reg    <= crc_next;
            len_reg    <= len_next;
            rd_vld_reg <= rd_vld_next;
            done_reg   <= done_next;
            if (cfg_valid && cfg_ready)
            begin
                count_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        crcs_reg   <= crcs_next;
        limit_reg  <= limit_next;
        rd_ptr_reg <= rd_ptr_next;
        found_reg  <= found_next;
        midx_reg   <= midx_next;
    end

    // crc is reset on the done cycle; result keeps a copy
    always_ff @(posedge clk)
    begin
        if (done_next)
        begin
            hl_reg <= crc_reg;
        end
    end

    assign done        = done_reg;
    assign hash_long   = ~hl_reg;
    assign hash_short  = ~crcs_reg;
    assign found       = found_reg;
    assign match_index = midx_reg;

`ifndef ASSERT_OFF
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> state_reg == ST_IDLE) else $error("done outside idle");
    a_found_idx: assert property (@(posedge clk) disable iff (!rst_n)
        done && !found |-> match_index == 10'd0) else $error("index without match");
    a_len_zero: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SRCH |-> len_reg == '0) else $error("name left in chain");
    a_crc_init: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> crc_reg == INIT_LONG) else $error("crc not restarted");
`endif

endmodule

[verif/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: name hash lookup check
// fills the hash table, then sends directed and random file names mixed with
// table loads; every lookup result is compared against a local crc/search model
// ----------------------------------------------------------------------------
module testbench
    import dchl_pkg::*;
();

    localparam int DEPTH    = 1024;
    localparam int NAME_MAX = 256;

    typedef struct packed {
        logic [31:0] hl;
        logic [15:0] hs;
        logic        hit;
        logic [9:0]  idx;
    } lookup_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic        action;
    logic [9:0]  entry_index;
    logic [31:0] entry_hash32;
    logic [15:0] entry_hash16;
    logic [7:0]  name_char;
    logic        last;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [10:0] cfg_data;
    logic        done;
    logic [31:0] hash_long;
    logic [15:0] hash_short;
    logic        found;
    logic [9:0]  match_index;

    // local copy of the block state
    logic [31:0] slot_long [DEPTH];
    logic [15:0] slot_short [DEPTH];
    logic [31:0] crc_run;
    logic [7:0]  chars_kept [NAME_MAX];
    int          kept_len;
    int          search_len;

    lookup_t     pending_lookups [$];
    int          mismatches;
    int          lookups_seen;
    int          hits_seen;
    int          items_sent;
    bit          idling_on;

    dual_crc_name_hash_lookup dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .action       (action),
        .entry_index  (entry_index),
        .entry_hash32 (entry_hash32),
        .entry_hash16 (entry_hash16),
        .name_char    (name_char),
        .last         (last),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .done         (done),
        .hash_long    (hash_long),
        .hash_short   (hash_short),
        .found        (found),
        .match_index  (match_index)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #30ms;
        $display("timeout");
        $display("Simulation FAILED");
        $finish;
    end

    function automatic logic [31:0] crc_long_step(logic [31:0] c, logic [7:0] ch);
        logic [31:0] s;
        s = c ^ {ch, 24'h0};
        for (int k = 0; k < 8; k++)
            s = s[31] ? ((s << 1) ^ 32'h04C1_1DB7) : (s << 1);
        return s;
    endfunction

    // 16-bit crc over the kept characters, newest first
    function automatic logic [15:0] crc_short_backwards(logic [7:0] q [$]);
        logic [15:0] s;
        s = 16'hFFFF;
        for (int n = q.size() - 1; n >= 0; n--)
        begin
            s = s ^ {q[n], 8'h0};
            for (int k = 0; k < 8; k++)
                s = s[15] ? ((s << 1) ^ 16'h1021) : (s << 1);
        end
        return ~s;
    endfunction

    function automatic lookup_t name_hashes(logic [7:0] name [$]);
        lookup_t     r;
        logic [31:0] c;
        logic [7:0]  kept [$];
        c = 32'hFFFF_FFFF;
        foreach (name[i])
        begin
            c = crc_long_step(c, name[i]);
            if (i < NAME_MAX)
                kept.push_back(name[i]);
        end
        r = '0;
        r.hl = ~c;
        r.hs = crc_short_backwards(kept);
        return r;
    endfunction

    task automatic predict_item(logic act, logic [9:0] slot, logic [31:0] h32,
                                logic [15:0] h16, logic [7:0] ch, logic fin);
        lookup_t    r;
        logic [7:0] kept [$];
        int         lim;
        if (act == ACT_LOAD)
        begin
            slot_long[slot]  = h32;
            slot_short[slot] = h16;
            return;
        end
        crc_run = crc_long_step(crc_run, ch);
        if (kept_len < NAME_MAX)
        begin
            chars_kept[kept_len] = ch;
            kept_len++;
        end
        if (!fin)
            return;
        for (int i = 0; i < kept_len; i++)
            kept.push_back(chars_kept[i]);
        r = '0;
        r.hl = ~crc_run;
        r.hs = crc_short_backwards(kept);
        lim = (search_len > DEPTH) ? DEPTH : search_len;
        for (int i = 0; i < lim; i++)
        begin
            if (slot_long[i] == r.hl && slot_short[i] == r.hs)
            begin
                r.hit = 1'b1;
                r.idx = 10'(i);
                break;
            end
        end
        pending_lookups.push_back(r);
        crc_run  = 32'hFFFF_FFFF;
        kept_len = 0;
    endtask

    // start is left high after acceptance; the next caller drives it in the same step
    task automatic send_item(logic act, logic [9:0] slot, logic [31:0] h32,
                             logic [15:0] h16, logic [7:0] ch, logic fin);
        if (idling_on && $urandom_range(0, 5) == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        start        <= 1'b1;
        action       <= act;
        entry_index  <= slot;
        entry_hash32 <= h32;
        entry_hash16 <= h16;
        name_char    <= ch;
        last         <= fin;
        do
        begin
            @(negedge clk);
        end
        while (busy);
        @(posedge clk);
        predict_item(act, slot, h32, h16, ch, fin);
        items_sent++;
    endtask

    task automatic load_slot(logic [9:0] slot, logic [31:0] h32, logic [15:0] h16);
        send_item(ACT_LOAD, slot, h32, h16, 8'($urandom), 1'($urandom));
    endtask

    // optional load items slipped in between characters
    task automatic send_name(logic [7:0] name [$], int noise_pct);
        foreach (name[i])
        begin
            if ($urandom_range(0, 99) < noise_pct)
                load_slot(10'($urandom_range(0, DEPTH - 1)), $urandom, 16'($urandom));
            send_item(ACT_CHAR, 10'($urandom), $urandom, 16'($urandom), name[i],
                      i == name.size() - 1);
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        do
        begin
            @(negedge clk);
        end
        while (pending_lookups.size() != 0 || busy);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_count(logic [10:0] value);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
        begin
            @(negedge clk);
        end
        while (!cfg_ready);
        @(posedge clk);
        cfg_valid  <= 1'b0;
        search_len = int'(value);
    endtask

    function automatic void random_name(ref logic [7:0] name [$], input int max_len);
        name.delete();
        repeat ($urandom_range(1, max_len))
            name.push_back(8'($urandom));
    endfunction

    always @(negedge clk)
    begin
        lookup_t want;
        if (rst_n && done)
        begin
            lookups_seen++;
            if (found)
                hits_seen++;
            if (pending_lookups.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t unexpected result hash_long=%h", $realtime, hash_long);
            end
            else
            begin
                want = pending_lookups.pop_front();
                if (hash_long !== want.hl || hash_short !== want.hs
                    || found !== want.hit || match_index !== want.idx)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t mismatch exp %h %h %b %0d got %h %h %b %0d",
                                 $realtime, want.hl, want.hs, want.hit, want.idx,
                                 hash_long, hash_short, found, match_index);
                end
            end
        end
    end

    task automatic test_fill_table();
        logic [7:0] name [$];
        write_count(11'd0);
        for (int i = 0; i < DEPTH; i++)
        begin
            if (i == 0)
                load_slot(10'(i), 32'h0, 16'h0);
            else if (i == DEPTH - 1)
                load_slot(10'(i), 32'hFFFF_FFFF, 16'hFFFF);
            else
                load_slot(10'(i), $urandom, 16'($urandom));
        end
        // nothing searched with a zero entry count
        name = '{8'h41};
        send_name(name, 0);
    endtask

    task automatic test_directed();
        logic [7:0] name [$];
        lookup_t    h;
        write_count(11'd16);
        name = '{8'h00, 8'hFF, 8'h80, 8'h01};
        h = name_hashes(name);
        load_slot(10'd9, h.hl, h.hs);
        load_slot(10'd5, h.hl, h.hs);
        send_name(name, 0);
        // single extreme characters
        name = '{8'h00};
        send_name(name, 0);
        name = '{8'hFF};
        h = name_hashes(name);
        load_slot(10'd0, h.hl, h.hs);
        send_name(name, 0);
        // only one hash matching is not a hit
        name = '{8'h6B, 8'h68};
        h = name_hashes(name);
        load_slot(10'd3, h.hl, ~h.hs);
        load_slot(10'd4, ~h.hl, h.hs);
        send_name(name, 50);
        // over-long name, tail only feeds the 32-bit crc
        random_name(name, 1);
        repeat (263) name.push_back(8'($urandom));
        h = name_hashes(name);
        load_slot(10'd15, h.hl, h.hs);
        send_name(name, 0);
        // whole table and a count past the table depth
        write_count(11'd1024);
        name = '{8'h2E, 8'h62, 8'h69, 8'h6E};
        h = name_hashes(name);
        load_slot(10'd1023, h.hl, h.hs);
        send_name(name, 0);
        write_count(11'd2047);
        send_name(name, 0);
        write_count(11'd1);
        send_name(name, 0);
    endtask

    task automatic test_random(int names, int max_count);
        logic [7:0] name [$];
        lookup_t    h;
        int         cnt;
        cnt = $urandom_range(1, max_count);
        write_count(11'(cnt));
        repeat (names)
        begin
            random_name(name, 12);
            if ($urandom_range(0, 99) < 45)
            begin
                h = name_hashes(name);
                load_slot(10'($urandom_range(0, cnt - 1)), h.hl, h.hs);
                if ($urandom_range(0, 3) == 0)
                    load_slot(10'($urandom_range(0, cnt - 1)), h.hl, h.hs);
            end
            send_name(name, 10);
        end
    endtask

    initial
    begin
        rst_n        = 1'b0;
        start        = 1'b0;
        action       = ACT_LOAD;
        entry_index  = '0;
        entry_hash32 = '0;
        entry_hash16 = '0;
        name_char    = '0;
        last         = 1'b0;
        cfg_valid    = 1'b0;
        cfg_data     = '0;
        crc_run      = 32'hFFFF_FFFF;
        kept_len     = 0;
        search_len   = 0;
        mismatches   = 0;
        lookups_seen = 0;
        hits_seen    = 0;
        items_sent   = 0;
        idling_on    = 1'b1;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_fill_table();
        test_directed();
        for (int p = 0; p < 2; p++)
            test_random(10, 64);
        test_random(4, 1024);
        idling_on = 1'b0;
        test_random(12, 200);

        drain();
        repeat (20) @(posedge clk);
        $display("sent %0d items, checked %0d lookups (%0d hits)",
                 items_sent, lookups_seen, hits_seen);
        $display("counts 0, 1, 16, 1024, 2047 and random; %0d mismatches", mismatches);
        if (mismatches == 0 && pending_lookups.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

[files.f]
hw/rtl/dchl_pkg.sv
hw/rtl/dchl_name_cell.sv
hw/rtl/dchl_name_chain.sv
hw/rtl/dual_crc_name_hash_lookup.sv
verif/testbench.sv
